FILE: rtl/nfhr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfhr_pkg
// Shared types and codes for the host frame receiver.
// ----------------------------------------------------------------------------
package nfhr_pkg;

   // Input beat kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // Final status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TIMEOUT     = 3'd1;
   localparam logic [2:0] ST_DATA_LOSS   = 3'd2;
   localparam logic [2:0] ST_TOO_LONG    = 3'd3;
   localparam logic [2:0] ST_ERROR_FRAME = 3'd4;
   localparam logic [2:0] ST_NO_ROOM     = 3'd5;

   // Frame bytes
   localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
   localparam logic [7:0] START_BYTE    = 8'hFF;
   localparam logic [7:0] TFI_TO_HOST   = 8'hD5;
   localparam logic [7:0] TFI_ERROR     = 8'h7F;

   // Register indexes
   localparam logic [1:0] REG_TIMEOUT_TICKS   = 2'd0;
   localparam logic [1:0] REG_MAX_FRAME_LEN   = 2'd1;
   localparam logic [1:0] REG_MAX_PAYLOAD_LEN = 2'd2;

   // Reset values of the registers
   localparam logic [15:0] RST_TIMEOUT_TICKS   = 16'd1000;
   localparam logic [7:0]  RST_MAX_FRAME_LEN   = 8'd255;
   localparam logic [7:0]  RST_MAX_PAYLOAD_LEN = 8'd255;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  max_len;
      logic [7:0]  max_payload_len;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
      logic [7:0] expected_cmd;
   } item_type;

   typedef struct packed {
      logic       is_status;
      logic [7:0] payload_byte;
      logic [2:0] status;
      logic [7:0] payload_len;
      logic       last;
   } result_type;

endpackage

FILE: rtl/nfhr_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfhr_csr
// Configuration registers: timeout, largest LEN and payload room.
// ----------------------------------------------------------------------------
module nfhr_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output nfhr_pkg::cfg_type cfg
);

   logic [15:0] timeout_ticks_ff;
   logic [7:0]  max_len_ff;
   logic [7:0]  max_payload_len_ff;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff   <= nfhr_pkg::RST_TIMEOUT_TICKS;
         max_len_ff         <= nfhr_pkg::RST_MAX_FRAME_LEN;
         max_payload_len_ff <= nfhr_pkg::RST_MAX_PAYLOAD_LEN;
      end else if (csr_we) begin
         case (csr_index)
            nfhr_pkg::REG_TIMEOUT_TICKS:   timeout_ticks_ff   <= csr_wdata;
            nfhr_pkg::REG_MAX_FRAME_LEN:   max_len_ff         <= csr_wdata[7:0];
            nfhr_pkg::REG_MAX_PAYLOAD_LEN: max_payload_len_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg.timeout_ticks   = timeout_ticks_ff;
   assign cfg.max_len         = max_len_ff;
   assign cfg.max_payload_len = max_payload_len_ff;

endmodule

FILE: rtl/nfhr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfhr_parser
// Frame state machine: one item per step, result decided in the same pass.
// ----------------------------------------------------------------------------
module nfhr_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  nfhr_pkg::item_type   item,
   input  nfhr_pkg::cfg_type    cfg,
   output logic                 res_valid,
   output nfhr_pkg::result_type res
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HUNT_ZERO,
      PH_HUNT_FF,
      PH_LEN,
      PH_LCS,
      PH_BODY
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  len_byte_ff, len_byte_in;
   logic [8:0]  body_count_ff, body_count_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [7:0]  tfi_seen_ff, tfi_seen_in;
   logic [7:0]  code_seen_ff, code_seen_in;
   logic [7:0]  dcs_seen_ff, dcs_seen_in;
   logic [7:0]  armed_cmd_ff, armed_cmd_in;
   logic [15:0] tick_count_ff, tick_count_in;

   logic [8:0]  len_ext;
   logic [9:0]  idx_plus1;
   logic [7:0]  plen;
   logic        emit_status;
   logic [2:0]  status_code;

   assign len_ext   = {1'b0, len_byte_ff};
   assign idx_plus1 = {1'b0, body_count_ff} + 10'd1;
   assign plen      = len_byte_ff - 8'd2;

   // Next state and result
   always_comb begin
      phase_in       = phase_ff;
      len_byte_in    = len_byte_ff;
      body_count_in  = body_count_ff;
      running_sum_in = running_sum_ff;
      tfi_seen_in    = tfi_seen_ff;
      code_seen_in   = code_seen_ff;
      dcs_seen_in    = dcs_seen_ff;
      armed_cmd_in   = armed_cmd_ff;
      tick_count_in  = tick_count_ff;
      res_valid      = 1'b0;
      emit_status    = 1'b0;
      status_code    = nfhr_pkg::ST_OK;
      res.is_status    = 1'b0;
      res.payload_byte = item.rx_byte;
      res.status       = nfhr_pkg::ST_OK;
      res.payload_len  = 8'd0;
      res.last         = 1'b0;

      if (item.kind == nfhr_pkg::KIND_START) begin
         armed_cmd_in   = item.expected_cmd;
         tick_count_in  = 16'd0;
         len_byte_in    = 8'd0;
         body_count_in  = 9'd0;
         running_sum_in = 8'd0;
         tfi_seen_in    = 8'd0;
         code_seen_in   = 8'd0;
         dcs_seen_in    = 8'd0;
         phase_in       = PH_HUNT_ZERO;
      end else if (phase_ff != PH_IDLE && item.kind == nfhr_pkg::KIND_TICK) begin
         // Saturating tick count toward the timeout
         if (tick_count_ff != 16'hFFFF) begin
            tick_count_in = tick_count_ff + 16'd1;
         end
         if (tick_count_in >= cfg.timeout_ticks) begin
            emit_status = 1'b1;
            status_code = nfhr_pkg::ST_TIMEOUT;
         end
      end else if (phase_ff != PH_IDLE && item.kind == nfhr_pkg::KIND_BYTE) begin
         case (phase_ff)
            PH_HUNT_ZERO: begin
               if (item.rx_byte == nfhr_pkg::PREAMBLE_BYTE) phase_in = PH_HUNT_FF;
            end
            PH_HUNT_FF: begin
               if (item.rx_byte == nfhr_pkg::START_BYTE) begin
                  phase_in = PH_LEN;
               end else if (item.rx_byte != nfhr_pkg::PREAMBLE_BYTE) begin
                  phase_in = PH_HUNT_ZERO;
               end
            end
            PH_LEN: begin
               len_byte_in = item.rx_byte;
               phase_in    = PH_LCS;
            end
            PH_LCS: begin
               if (len_byte_ff + item.rx_byte != 8'd0) begin
                  emit_status = 1'b1;
                  status_code = nfhr_pkg::ST_DATA_LOSS;
               end else if (len_byte_ff > cfg.max_len) begin
                  emit_status = 1'b1;
                  status_code = nfhr_pkg::ST_TOO_LONG;
               end else begin
                  body_count_in  = 9'd0;
                  running_sum_in = 8'd0;
                  phase_in       = PH_BODY;
               end
            end
            PH_BODY: begin
               // Capture by position: TFI, response code, DCS
               if (body_count_ff == 9'd0) tfi_seen_in = item.rx_byte;
               if (body_count_ff == 9'd1) code_seen_in = item.rx_byte;
               if (body_count_ff == len_ext) dcs_seen_in = item.rx_byte;
               if (body_count_ff < len_ext) begin
                  running_sum_in = running_sum_ff + item.rx_byte;
               end
               body_count_in = idx_plus1[8:0];
               if (body_count_ff >= 9'd2 && body_count_ff < len_ext) begin
                  res_valid = 1'b1;
               end
               // Final checks once LEN+2 bytes are in
               if (idx_plus1 >= {2'b00, len_byte_ff} + 10'd2) begin
                  emit_status = 1'b1;
                  if (tfi_seen_in == nfhr_pkg::TFI_ERROR) begin
                     status_code = nfhr_pkg::ST_ERROR_FRAME;
                  end else if (tfi_seen_in != nfhr_pkg::TFI_TO_HOST) begin
                     status_code = nfhr_pkg::ST_DATA_LOSS;
                  end else if ({1'b0, code_seen_in} != {1'b0, armed_cmd_ff} + 9'd1) begin
                     status_code = nfhr_pkg::ST_DATA_LOSS;
                  end else if (running_sum_in + dcs_seen_in != 8'd0) begin
                     status_code = nfhr_pkg::ST_DATA_LOSS;
                  end else if (len_byte_ff < 8'd2 || plen > cfg.max_payload_len) begin
                     status_code = nfhr_pkg::ST_NO_ROOM;
                  end else begin
                     status_code = nfhr_pkg::ST_OK;
                  end
               end
            end
            default: ;
         endcase
      end

      // A status beat overrides any payload beat and ends the frame
      if (emit_status) begin
         phase_in         = PH_IDLE;
         res_valid        = 1'b1;
         res.is_status    = 1'b1;
         res.payload_byte = 8'd0;
         res.status       = status_code;
         res.payload_len  = (status_code == nfhr_pkg::ST_OK) ? plen : 8'd0;
         res.last         = 1'b1;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         len_byte_ff    <= 8'd0;
         body_count_ff  <= 9'd0;
         running_sum_ff <= 8'd0;
         tfi_seen_ff    <= 8'd0;
         code_seen_ff   <= 8'd0;
         dcs_seen_ff    <= 8'd0;
         armed_cmd_ff   <= 8'd0;
         tick_count_ff  <= 16'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         len_byte_ff    <= len_byte_in;
         body_count_ff  <= body_count_in;
         running_sum_ff <= running_sum_in;
         tfi_seen_ff    <= tfi_seen_in;
         code_seen_ff   <= code_seen_in;
         dcs_seen_ff    <= dcs_seen_in;
         armed_cmd_ff   <= armed_cmd_in;
         tick_count_ff  <= tick_count_in;
      end
   end

endmodule

FILE: rtl/nfc_host_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_host_frame_receiver_unit
// Host-side receiver for one reader response frame, fed byte by byte.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle: start, received byte or timer tick. A beat
// is held in an input register and decided in a single pass by the frame
// state machine, so a result (payload byte or final status) goes into the
// output register that drives the rsp_ side. Throughput is one beat a cycle
// while rsp_tready is high; a stalled result holds in the output register
// while one further beat is taken into the input register. The user must
// write registers through csr_ only while no frame is in flight; not enforced.
// ----------------------------------------------------------------------------
module nfc_host_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   // Request beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] rx_byte, [15:8] expected_cmd
   input  logic [1:0]  req_tuser,  // [1:0] kind
   // Result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [7:0] payload_byte, [10:8] status,
                                   // [18:11] payload_len, [23:19] zero
   output logic        rsp_tuser,  // [0] is_status
   output logic        rsp_tlast,  // last
   // Configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   nfhr_pkg::cfg_type    cfg;
   nfhr_pkg::item_type   item_ff, item_in;
   nfhr_pkg::result_type res;
   nfhr_pkg::result_type out_ff;
   logic                 in_vld_ff;
   logic                 out_vld_ff;
   logic                 res_valid;
   logic                 advance;

   // Item moves on when the output register is free or being drained
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   assign item_in.kind         = req_tuser;
   assign item_in.rx_byte      = req_tdata[7:0];
   assign item_in.expected_cmd = req_tdata[15:8];

   nfhr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nfhr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (item_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= res_valid;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, out_ff.payload_len, out_ff.status, out_ff.payload_byte};
   assign rsp_tuser  = out_ff.is_status;
   assign rsp_tlast  = out_ff.last;

   // A status beat always closes the frame, a payload beat never does
   a_last_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast))
      else $error("last does not match status beat");

   // Payload length only reported with ok status
   a_len_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_ff.status != nfhr_pkg::ST_OK) |-> (out_ff.payload_len == 8'd0))
      else $error("payload length on non-ok status");

   // A held input item is not lost while the output stalls
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(item_ff))
      else $error("input item dropped during stall");

   // A pending result is only replaced after it was taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |=> out_vld_ff && $stable(out_ff))
      else $error("pending result overwritten");

endmodule

FILE: tb/tb_nfc_host_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nfc_host_frame_receiver_unit
// Self-checking bench for the host-side reader frame receiver.
// ----------------------------------------------------------------------------
// An initial block fills a queue of request beats: a short directed run over
// idle beats, a bad length checksum, a restart mid-frame and a good frame,
// then random frames with random flaws, ticks and noise under several
// register settings. A clocked driver plays the queue onto req_ with random
// gaps; every accepted beat goes through a local frame predictor that queues
// the expected payload and status beats. A clocked monitor stalls rsp_ at
// random and checks each result beat field by field against the oldest
// expectation.
// ----------------------------------------------------------------------------
module tb_nfc_host_frame_receiver_unit;

   // Kind with no meaning to the block
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef enum logic [3:0] {
      RX_IDLE, RX_HUNT_ZERO, RX_HUNT_FF, RX_LEN, RX_LCS, RX_BODY
   } rx_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] rx_byte, [15:8] expected_cmd
   logic [1:0]  req_tuser = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] payload_byte, [10:8] status,
                                  // [18:11] payload_len, [23:19] zero
   logic        rsp_tuser;        // [0] is_status
   logic        rsp_tlast;        // last
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   nfc_host_frame_receiver_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   nfhr_pkg::item_type   beat_q[$];        // request beats still to send
   nfhr_pkg::result_type rx_expect_q[$];   // result beats still to arrive
   int         mismatches = 0;
   int         beats_queued = 0;
   bit         no_idle = 1'b0;

   // Local copy of the registers and of the receiver state
   nfhr_pkg::cfg_type rx_cfg = '{nfhr_pkg::RST_TIMEOUT_TICKS, nfhr_pkg::RST_MAX_FRAME_LEN,
                                 nfhr_pkg::RST_MAX_PAYLOAD_LEN};
   rx_phase_type rx_phase = RX_IDLE;
   logic [7:0] rx_len = '0;
   logic [8:0] body_count = '0;
   logic [7:0] running_sum = '0;
   logic [7:0] tfi_seen = '0;
   logic [7:0] code_seen = '0;
   logic [7:0] dcs_seen = '0;
   logic [7:0] armed_cmd = '0;
   logic [15:0] tick_count = '0;

   // Gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ------------------------------------------------------------------
   // Frame predictor
   // ------------------------------------------------------------------
   task automatic close_frame(input logic [2:0] st, input logic [7:0] plen);
      nfhr_pkg::result_type r;
      r.is_status    = 1'b1;
      r.payload_byte = '0;
      r.status       = st;
      r.payload_len  = (st == nfhr_pkg::ST_OK) ? plen : 8'd0;
      r.last         = 1'b1;
      rx_expect_q.push_back(r);
      rx_phase = RX_IDLE;
   endtask

   task automatic predict_beat(input nfhr_pkg::item_type it);
      logic [7:0] b;
      logic [7:0] s8;
      logic [7:0] plen;
      logic [8:0] idx;
      nfhr_pkg::result_type r;
      b = it.rx_byte;
      if (it.kind == nfhr_pkg::KIND_START) begin
         armed_cmd   = it.expected_cmd;
         tick_count  = '0;
         rx_len      = '0;
         body_count  = '0;
         running_sum = '0;
         tfi_seen    = '0;
         code_seen   = '0;
         dcs_seen    = '0;
         rx_phase    = RX_HUNT_ZERO;
      end else if (rx_phase != RX_IDLE && it.kind == nfhr_pkg::KIND_BYTE) begin
         case (rx_phase)
            RX_HUNT_ZERO: begin
               if (b == nfhr_pkg::PREAMBLE_BYTE) rx_phase = RX_HUNT_FF;
            end
            RX_HUNT_FF: begin
               if (b == nfhr_pkg::START_BYTE) rx_phase = RX_LEN;
               else if (b != nfhr_pkg::PREAMBLE_BYTE) rx_phase = RX_HUNT_ZERO;
            end
            RX_LEN: begin
               rx_len   = b;
               rx_phase = RX_LCS;
            end
            RX_LCS: begin
               s8 = rx_len + b;
               if (s8 != 8'd0) close_frame(nfhr_pkg::ST_DATA_LOSS, 8'd0);
               else if (rx_len > rx_cfg.max_len) close_frame(nfhr_pkg::ST_TOO_LONG, 8'd0);
               else begin
                  body_count  = '0;
                  running_sum = '0;
                  rx_phase    = RX_BODY;
               end
            end
            RX_BODY: begin
               idx = body_count;
               if (idx == 9'd0) tfi_seen = b;
               if (idx == 9'd1) code_seen = b;
               if (idx == {1'b0, rx_len}) dcs_seen = b;
               if (idx < {1'b0, rx_len}) running_sum = running_sum + b;
               body_count = idx + 9'd1;
               // payload bytes go straight out
               if (idx >= 9'd2 && idx < {1'b0, rx_len}) begin
                  r.is_status    = 1'b0;
                  r.payload_byte = b;
                  r.status       = nfhr_pkg::ST_OK;
                  r.payload_len  = '0;
                  r.last         = 1'b0;
                  rx_expect_q.push_back(r);
               end
               // last body byte: run the final checks in order
               if ({1'b0, idx} + 10'd1 >= {2'b00, rx_len} + 10'd2) begin
                  plen = rx_len - 8'd2;
                  s8   = running_sum + dcs_seen;
                  if (tfi_seen == nfhr_pkg::TFI_ERROR)
                     close_frame(nfhr_pkg::ST_ERROR_FRAME, 8'd0);
                  else if (tfi_seen != nfhr_pkg::TFI_TO_HOST)
                     close_frame(nfhr_pkg::ST_DATA_LOSS, 8'd0);
                  else if ({1'b0, code_seen} != {1'b0, armed_cmd} + 9'd1)
                     close_frame(nfhr_pkg::ST_DATA_LOSS, 8'd0);
                  else if (s8 != 8'd0) close_frame(nfhr_pkg::ST_DATA_LOSS, 8'd0);
                  else if (rx_len < 8'd2 || plen > rx_cfg.max_payload_len)
                     close_frame(nfhr_pkg::ST_NO_ROOM, 8'd0);
                  else close_frame(nfhr_pkg::ST_OK, plen);
               end
            end
            default: ;
         endcase
      end else if (rx_phase != RX_IDLE && it.kind == nfhr_pkg::KIND_TICK) begin
         if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
         if (tick_count >= rx_cfg.timeout_ticks) close_frame(nfhr_pkg::ST_TIMEOUT, 8'd0);
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: accept at rising edge, drive at falling edge
   // ------------------------------------------------------------------
   int gap_left = 0;
   bit req_sent;

   always begin
      @(posedge clock);
      req_sent = 1'b0;
      if (!reset && req_tvalid && req_tready === 1'b1) begin
         predict_beat(beat_q.pop_front());
         gap_left = no_idle ? 0 : pick_gap();
         req_sent = 1'b1;
      end
      @(negedge clock);
      if (req_tvalid && !req_sent) begin
         // hold the beat until taken
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left   = gap_left - 1;
      end else if (beat_q.size() != 0) begin
         req_tvalid <= 1'b1;
         req_tdata  <= {beat_q[0].expected_cmd, beat_q[0].rx_byte};
         req_tuser  <= beat_q[0].kind;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check at rising edge, stall at falling edge
   // ------------------------------------------------------------------
   int stall_left = 0;

   always begin
      nfhr_pkg::result_type got;
      nfhr_pkg::result_type want;
      @(posedge clock);
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.is_status    = rsp_tuser;
         got.payload_byte = rsp_tdata[7:0];
         got.status       = rsp_tdata[10:8];
         got.payload_len  = rsp_tdata[18:11];
         got.last         = rsp_tlast;
         if (rx_expect_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result beat: expected none, actual", $time,
                     " is_status=%0d byte=%02h status=%0d len=%0d last=%0d",
                     got.is_status, got.payload_byte, got.status,
                     got.payload_len, got.last);
         end else begin
            want = rx_expect_q.pop_front();
            if (got.is_status !== want.is_status || got.payload_byte !== want.payload_byte ||
                got.status !== want.status || got.payload_len !== want.payload_len ||
                got.last !== want.last) begin
               mismatches++;
               $display("%0t: mismatch: expected is_status=%0d byte=%02h status=%0d",
                        $time, want.is_status, want.payload_byte, want.status,
                        " len=%0d last=%0d", want.payload_len, want.last);
               $display("%0t:           actual   is_status=%0d byte=%02h status=%0d",
                        $time, got.is_status, got.payload_byte, got.status,
                        " len=%0d last=%0d", got.payload_len, got.last);
            end
         end
      end
      @(negedge clock);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_beat(input logic [1:0] k, input logic [7:0] b, input logic [7:0] c);
      nfhr_pkg::item_type it;
      it.kind         = k;
      it.rx_byte      = b;
      it.expected_cmd = c;
      beat_q.push_back(it);
      beats_queued++;
   endtask

   // Link byte, now and then preceded by a timer tick
   task automatic push_link_byte(input logic [7:0] b);
      if ($urandom_range(0, 11) == 0)
         push_beat(nfhr_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
      push_beat(nfhr_pkg::KIND_BYTE, b, 8'($urandom));
   endtask

   // All three registers in back-to-back cycles; block must be idle
   task automatic write_regs(input logic [15:0] tmo, input logic [7:0] mfl,
                             input logic [7:0] mpl);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= nfhr_pkg::REG_TIMEOUT_TICKS;
      csr_wdata <= tmo;
      @(negedge clock);
      csr_index <= nfhr_pkg::REG_MAX_FRAME_LEN;
      csr_wdata <= {8'h00, mfl};
      @(negedge clock);
      csr_index <= nfhr_pkg::REG_MAX_PAYLOAD_LEN;
      csr_wdata <= {8'h00, mpl};
      @(negedge clock);
      csr_we    <= 1'b0;
      rx_cfg.timeout_ticks   = tmo;
      rx_cfg.max_len         = mfl;
      rx_cfg.max_payload_len = mpl;
   endtask

   // Sender holds off until every expected result is back
   task automatic drain();
      while (beat_q.size() != 0 || rx_expect_q.size() != 0) @(posedge clock);
   endtask

   // Drain, then allow for beats still in the pipeline that give no result
   task automatic settle();
      drain();
      repeat (6) @(posedge clock);
   endtask

   // One response frame, well formed or with one flaw
   task automatic send_frame();
      int         flav;
      int         r;
      int         len;
      int         cut;
      int         i;
      logic [7:0] cmd;
      logic [7:0] tfi;
      logic [7:0] code;
      logic [7:0] lcs;
      logic [7:0] sum;
      logic [7:0] r8;
      logic [7:0] fbody[$];
      flav = $urandom_range(0, 99);
      cmd  = (flav < 4) ? 8'hFF : 8'($urandom);
      r    = $urandom_range(0, 99);
      len  = (r < 80) ? $urandom_range(2, 10) :
             (r < 97) ? $urandom_range(11, 42) : $urandom_range(200, 255);
      tfi  = nfhr_pkg::TFI_TO_HOST;
      if (flav >= 4 && flav < 10) begin
         // short length: LEN 1 with a checksum that works out gives no room
         len = $urandom_range(0, 1);
         if (len == 1) cmd = 8'h2A;
      end
      if (flav >= 10 && flav < 16) tfi = nfhr_pkg::TFI_ERROR;
      if (flav >= 16 && flav < 22) begin
         tfi = 8'($urandom);
         if (tfi == nfhr_pkg::TFI_TO_HOST) tfi = 8'h00;
      end
      code = cmd + 8'd1;
      if (flav >= 22 && flav < 28) begin
         r8   = 8'($urandom_range(1, 255));
         code = code + r8;
      end
      if (flav >= 42 && flav < 48 && rx_cfg.max_len != 8'hFF)
         len = $urandom_range(rx_cfg.max_len + 1, 255);
      lcs = 8'h00 - 8'(len);
      if (flav >= 36 && flav < 42) begin
         r8  = 8'($urandom_range(1, 255));
         lcs = lcs + r8;
      end

      // body bytes by position: TFI, code, payload, DCS, postamble
      for (i = 0; i < len + 2; i++) fbody.push_back(8'($urandom));
      fbody[0] = tfi;
      fbody[1] = code;
      if (len >= 2) begin
         sum = '0;
         for (i = 0; i < len; i++) sum = sum + fbody[i];
         fbody[len] = 8'h00 - sum;
         if (flav >= 28 && flav < 36) begin
            r8 = 8'($urandom_range(1, 255));
            fbody[len] = fbody[len] + r8;
         end
         fbody[len + 1] = nfhr_pkg::PREAMBLE_BYTE;
      end
      cut = (flav >= 48 && flav < 56) ? $urandom_range(0, len) : len + 2;

      push_beat(nfhr_pkg::KIND_START, 8'($urandom), cmd);
      r = $urandom_range(0, 2);
      for (i = 0; i < r; i++) push_link_byte(8'($urandom_range(1, 255)));
      if (flav >= 56 && flav < 60) begin
         // broken start code, then a clean one
         push_link_byte(nfhr_pkg::PREAMBLE_BYTE);
         push_link_byte(8'($urandom_range(1, 254)));
      end
      r = $urandom_range(1, 3);
      for (i = 0; i < r; i++) push_link_byte(nfhr_pkg::PREAMBLE_BYTE);
      push_link_byte(nfhr_pkg::START_BYTE);
      push_link_byte(8'(len));
      push_link_byte(lcs);
      // nothing more is read after a bad LCS or a LEN that is too large
      if ((flav >= 36 && flav < 48) || len > rx_cfg.max_len) cut = 0;
      for (i = 0; i < cut; i++) push_link_byte(fbody[i]);
   endtask

   // Random frames with a little noise between them
   task automatic run_random(input int n_beats);
      int target;
      int i;
      int n;
      target = beats_queued + n_beats;
      while (beats_queued < target) begin
         if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
               push_beat(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
         end
         send_frame();
         if ($urandom_range(0, 19) == 0) drain();
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int ph;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings
      push_beat(nfhr_pkg::KIND_BYTE, 8'hFF, 8'h00);   // ignored while idle
      push_beat(nfhr_pkg::KIND_TICK, 8'h00, 8'hFF);   // ignored while idle
      push_beat(KIND_UNUSED, 8'hFF, 8'hFF);           // unknown kind
      // bad LCS
      push_beat(nfhr_pkg::KIND_START, 8'h00, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, nfhr_pkg::PREAMBLE_BYTE, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, nfhr_pkg::START_BYTE, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'h03, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'h00, 8'h00);
      // frame cut short by a new start
      push_beat(nfhr_pkg::KIND_START, 8'h00, 8'h10);
      push_beat(nfhr_pkg::KIND_BYTE, nfhr_pkg::PREAMBLE_BYTE, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, nfhr_pkg::PREAMBLE_BYTE, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, nfhr_pkg::START_BYTE, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'h03, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'hFD, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, nfhr_pkg::TFI_TO_HOST, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'h11, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'hA5, 8'h00);
      // good frame for command FE, one payload byte
      push_beat(nfhr_pkg::KIND_START, 8'h00, 8'hFE);
      push_beat(nfhr_pkg::KIND_BYTE, nfhr_pkg::PREAMBLE_BYTE, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, nfhr_pkg::START_BYTE, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'h03, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'hFD, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, nfhr_pkg::TFI_TO_HOST, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'hFF, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'h5A, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, 8'hD2, 8'h00);
      push_beat(nfhr_pkg::KIND_BYTE, nfhr_pkg::PREAMBLE_BYTE, 8'h00);
      settle();

      // Random phases over several register settings
      for (ph = 1; ph <= 5; ph++) begin
         case (ph)
            1: begin write_regs(16'hFFFF, 8'hFF, 8'hFF); no_idle = 1'b0; end
            2: begin write_regs(16'h0000, 8'h00, 8'h00); no_idle = 1'b1; end
            3: begin write_regs(16'd40, 8'd20, 8'd8);    no_idle = 1'b0; end
            4: begin write_regs(16'd3, 8'hFF, 8'd2);     no_idle = 1'b0; end
            default: begin
               write_regs(16'($urandom_range(5, 300)), 8'($urandom), 8'($urandom));
               no_idle = 1'b0;
            end
         endcase
         run_random(140);
         settle();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && rx_expect_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/nfhr_pkg.sv
rtl/nfhr_csr.sv
rtl/nfhr_parser.sv
rtl/nfc_host_frame_receiver_unit.sv
tb/tb_nfc_host_frame_receiver_unit.sv
